// ----- rtl/fffrt_pkg.sv -----
// Shared constants for the first-fit free run tracker.
// No dependencies; imported by first_fit_free_run_tracker.
package fffrt_pkg;

    localparam int unsigned FIELD_W = 13;

    // Run lengths saturate here; the free tail always carries this length.
    localparam logic [FIELD_W-1:0] RUN_SAT = 13'h1FFF;

    // Operation codes on func
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;    // unused code, no state change

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;

    // Tree update jobs after the neighbor searches
    typedef enum logic [1:0] {
        JOB_OCC,
        JOB_RA,
        JOB_RB,
        JOB_END
    } job_t;

endpackage

// ----- rtl/first_fit_free_run_tracker.sv -----
// First-fit free run tracker: occupancy tree plus max tree of free-run lengths,
// both held in single-port-read synchronous memories. Depends on fffrt_pkg.
//
// The block tracks positions 1..POSITIONS as free or occupied; everything above
// POSITIONS is an endless free tail. Each input beat carries func and value:
// insert (mark value occupied), remove (free it) or query (leftmost start of a
// free run of at least value positions). Every beat yields exactly one result
// beat with answer and status. After reset the block runs a clearing pass over
// all 2*N memory entries (N = POSITIONS rounded up to a power of two) and takes
// no item until it is done. Items are worked on one at a time. An insert or
// remove first searches the occupancy tree for the nearest occupied position on
// each side, then rewrites up to three leaf-to-root paths (the third only when
// value is below POSITIONS), each after a setup state. The sequencer issues
// at most one read and one write per memory per cycle and never to the same
// entry, so no forwarding path is needed. A finished result sits in an output
// register while the next beat is taken.

module first_fit_free_run_tracker
    import fffrt_pkg::*;
#(
    parameter int POSITIONS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  func,
    input  logic [12:0] value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [12:0] answer,
    output logic [1:0]  status
);

    localparam int LVL  = $clog2(POSITIONS);
    localparam int NW   = LVL + 1;                       // tree node index width
    localparam int PW0  = $clog2(POSITIONS + 2);
    localparam int PW   = (PW0 > 13) ? PW0 : 14;         // position arithmetic width
    localparam int DEPTH = 2 ** NW;
    localparam logic [PW-1:0] P_POS = PW'(POSITIONS);

    // sequencer states
    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHK      = 4'd2;
    localparam logic [3:0] S_UP       = 4'd3;
    localparam logic [3:0] S_UPCHK    = 4'd4;
    localparam logic [3:0] S_DN       = 4'd5;
    localparam logic [3:0] S_DNCHK    = 4'd6;
    localparam logic [3:0] S_SETUP    = 4'd7;
    localparam logic [3:0] S_UPD_W    = 4'd8;
    localparam logic [3:0] S_UPD_R    = 4'd9;
    localparam logic [3:0] S_Q_ROOT   = 4'd10;
    localparam logic [3:0] S_Q_DN     = 4'd11;
    localparam logic [3:0] S_Q_DNCHK  = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    function automatic logic [NW-1:0] leaf_of(input logic [PW-1:0] pos);
        logic [PW-1:0] t;
        t = pos - PW'(1);
        return {1'b1, t[LVL-1:0]};
    endfunction

    function automatic logic [PW-1:0] pos_of(input logic [NW-1:0] n);
        return PW'(n[LVL-1:0]) + PW'(1);
    endfunction

    function automatic logic [12:0] sat13(input logic [PW-1:0] x);
        return (x > PW'(RUN_SAT)) ? RUN_SAT : x[12:0];
    endfunction

    // Memories: occupancy OR tree and run-length max tree, heap order, node 1 = root
    logic        occ_mem [0:DEPTH-1];
    logic [12:0] run_mem [0:DEPTH-1];

    logic          occ_we, occ_re, occ_wdata, occ_q;
    logic [NW-1:0] occ_waddr, occ_raddr;
    logic          run_we, run_re;
    logic [12:0]   run_wdata, run_q;
    logic [NW-1:0] run_waddr, run_raddr;

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re)
        begin
            occ_q <= occ_mem[occ_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
        if (run_re)
        begin
            run_q <= run_mem[run_raddr];
        end
    end

    // control and working registers
    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;          // clearing pass address
    logic [1:0]    func_reg, func_next;
    logic [PW-1:0] v_reg, v_next;              // position, or k for a query
    logic [NW-1:0] n_reg, n_next;              // current tree node
    logic          dir_reg, dir_next;          // 0: left neighbor, 1: right neighbor
    logic [PW-1:0] s_reg, s_next;              // start of the affected run
    logic [PW-1:0] e_reg, e_next;              // end of the affected run
    job_t          job_reg, job_next;
    logic          t_reg, t_next;              // 0: occupancy tree, 1: run tree
    logic [12:0]   val_reg, val_next;          // value climbing the tree
    logic [12:0]   ans_reg, ans_next;
    logic [1:0]    st_reg, st_next;
    logic          rv_reg, rv_next;
    logic [12:0]   answer_reg, answer_next;
    logic [1:0]    status_reg, status_next;

    logic          is_ins;
    logic [12:0]   len_a, len_b;
    logic [PW-1:0] found_pos;

    assign is_ins    = (func_reg == FN_INSERT);
    assign found_pos = pos_of(n_reg);

    // new run lengths for the left leaf (run start) and the leaf after v
    always_comb
    begin
        if (is_ins)
        begin
            len_a = sat13(v_reg - s_reg);
            len_b = (e_reg == P_POS) ? RUN_SAT : sat13(e_reg - v_reg);
        end
        else
        begin
            len_a = (e_reg == P_POS) ? RUN_SAT : sat13(e_reg - s_reg + PW'(1));
            len_b = 13'd0;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign answer       = answer_reg;
    assign status       = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        func_next   = func_reg;
        v_next      = v_reg;
        n_next      = n_reg;
        dir_next    = dir_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        job_next    = job_reg;
        t_next      = t_reg;
        val_next    = val_reg;
        ans_next    = ans_reg;
        st_next     = st_reg;
        rv_next     = rv_reg;
        answer_next = answer_reg;
        status_next = status_reg;

        occ_we    = 1'b0;
        occ_waddr = n_reg;
        occ_wdata = val_reg[0];
        occ_re    = 1'b0;
        occ_raddr = n_reg ^ NW'(1);
        run_we    = 1'b0;
        run_waddr = n_reg;
        run_wdata = val_reg;
        run_re    = 1'b0;
        run_raddr = n_reg ^ NW'(1);

        if (rv_reg && result_ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // root-to-leaf-1 path holds the saturated tail run, all else zero
                occ_we    = 1'b1;
                occ_waddr = cnt_reg;
                occ_wdata = 1'b0;
                run_we    = 1'b1;
                run_waddr = cnt_reg;
                run_wdata = ((cnt_reg != '0) && ((cnt_reg & (cnt_reg - NW'(1))) == '0))
                            ? RUN_SAT : 13'd0;
                cnt_next  = cnt_reg + NW'(1);
                if (cnt_reg == NW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    func_next = func;
                    v_next    = PW'(value);
                    ans_next  = 13'd0;
                    st_next   = ST_OK;
                    if (func == FN_QUERY)
                    begin
                        run_re     = 1'b1;
                        run_raddr  = NW'(1);
                        state_next = S_Q_ROOT;
                    end
                    else if (func == FN_INSERT || func == FN_REMOVE)
                    begin
                        if (value == 13'd0 || PW'(value) > P_POS)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            occ_re     = 1'b1;
                            occ_raddr  = leaf_of(PW'(value));
                            state_next = S_CHK;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CHK:
            begin
                if (occ_q == is_ins)
                begin
                    st_next    = ST_SAME;
                    state_next = S_DONE;
                end
                else
                begin
                    dir_next   = 1'b0;
                    n_next     = leaf_of(v_reg);
                    state_next = S_UP;
                end
            end

            // climb until a sibling on the search side holds an occupied position
            S_UP:
            begin
                if (n_reg == NW'(1))
                begin
                    if (!dir_reg)
                    begin
                        s_next     = PW'(1);
                        dir_next   = 1'b1;
                        n_next     = leaf_of(v_reg);
                        state_next = S_UP;
                    end
                    else
                    begin
                        e_next     = P_POS;
                        job_next   = JOB_OCC;
                        state_next = S_SETUP;
                    end
                end
                else if (n_reg[0] != dir_reg)
                begin
                    occ_re     = 1'b1;
                    state_next = S_UPCHK;
                end
                else
                begin
                    n_next = n_reg >> 1;
                end
            end

            S_UPCHK:
            begin
                if (occ_q)
                begin
                    n_next     = n_reg ^ NW'(1);
                    state_next = S_DN;
                end
                else
                begin
                    n_next     = n_reg >> 1;
                    state_next = S_UP;
                end
            end

            // descend toward v: prefer the child nearer to v
            S_DN:
            begin
                if (n_reg[NW-1])
                begin
                    if (!dir_reg)
                    begin
                        s_next     = found_pos + PW'(1);
                        dir_next   = 1'b1;
                        n_next     = leaf_of(v_reg);
                        state_next = S_UP;
                    end
                    else
                    begin
                        e_next     = found_pos - PW'(1);
                        job_next   = JOB_OCC;
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    occ_re     = 1'b1;
                    occ_raddr  = {n_reg[NW-2:0], ~dir_reg};
                    state_next = S_DNCHK;
                end
            end

            S_DNCHK:
            begin
                n_next     = {n_reg[NW-2:0], occ_q ? ~dir_reg : dir_reg};
                state_next = S_DN;
            end

            S_SETUP:
            begin
                state_next = S_UPD_W;
                case (job_reg)
                    JOB_OCC:
                    begin
                        t_next   = 1'b0;
                        n_next   = leaf_of(v_reg);
                        val_next = {12'd0, is_ins};
                        job_next = JOB_RA;
                    end
                    JOB_RA:
                    begin
                        t_next   = 1'b1;
                        n_next   = leaf_of(s_reg);
                        val_next = len_a;
                        job_next = JOB_RB;
                    end
                    JOB_RB:
                    begin
                        job_next = JOB_END;
                        if (v_reg < P_POS)
                        begin
                            t_next   = 1'b1;
                            n_next   = leaf_of(v_reg + PW'(1));
                            val_next = len_b;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // write node, fetch sibling, combine into parent
            S_UPD_W:
            begin
                occ_we = ~t_reg;
                run_we = t_reg;
                if (n_reg == NW'(1))
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    occ_re     = ~t_reg;
                    run_re     = t_reg;
                    state_next = S_UPD_R;
                end
            end

            S_UPD_R:
            begin
                if (t_reg)
                begin
                    val_next = (run_q > val_reg) ? run_q : val_reg;
                end
                else
                begin
                    val_next = {12'd0, val_reg[0] | occ_q};
                end
                n_next     = n_reg >> 1;
                state_next = S_UPD_W;
            end

            S_Q_ROOT:
            begin
                if (PW'(run_q) < v_reg)
                begin
                    ans_next   = 13'(POSITIONS + 1);
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = NW'(1);
                    state_next = S_Q_DN;
                end
            end

            S_Q_DN:
            begin
                if (n_reg[NW-1])
                begin
                    ans_next   = found_pos[12:0];
                    state_next = S_DONE;
                end
                else
                begin
                    run_re     = 1'b1;
                    run_raddr  = {n_reg[NW-2:0], 1'b0};
                    state_next = S_Q_DNCHK;
                end
            end

            S_Q_DNCHK:
            begin
                n_next     = {n_reg[NW-2:0], (PW'(run_q) >= v_reg) ? 1'b0 : 1'b1};
                state_next = S_Q_DN;
            end

            S_DONE:
            begin
                if (!rv_reg || result_ready)
                begin
                    rv_next     = 1'b1;
                    answer_next = ans_reg;
                    status_next = st_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            job_reg   <= JOB_OCC;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
            job_reg   <= job_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        v_reg      <= v_next;
        n_reg      <= n_next;
        dir_reg    <= dir_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        t_reg      <= t_next;
        val_reg    <= val_next;
        ans_reg    <= ans_next;
        st_reg     <= st_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    // no read and write to the same entry in one cycle
    a_occ_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_we && occ_re) |-> (occ_waddr != occ_raddr))
        else $error("occupancy tree read/write collision");

    a_run_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (run_we && run_re) |-> (run_waddr != run_raddr))
        else $error("run tree read/write collision");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("accepted a beat while still working");

    a_flag_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_OK) |-> (answer == 13'd0))
        else $error("flagged result carries an answer");

endmodule

// ----- sim/first_fit_free_run_tracker_test.sv -----
// Self-checking testbench for first_fit_free_run_tracker: queue-fed driver,
// clocked monitor, and a behavioral occupancy/first-fit predictor. Needs fffrt_pkg.
`timescale 1ns / 100ps

module first_fit_free_run_tracker_test;
    import fffrt_pkg::*;

    localparam int NPOS = 4096;
    localparam int STALL_LIMIT = 40000;  // covers the clearing pass after reset

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  func = '0;
    logic [12:0] value = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [12:0] answer;
    logic [1:0]  status;

    first_fit_free_run_tracker #(.POSITIONS(NPOS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .func(func), .value(value),
        .result_valid(result_valid), .result_ready(result_ready),
        .answer(answer), .status(status)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] value;
    } op_beat_t;

    typedef struct packed {
        logic [12:0] answer;
        logic [1:0]  status;
    } fit_result_t;

    op_beat_t    pending_ops[$];
    fit_result_t expected_fits[$];

    // Predictor state: occupancy only; first fit is found by a direct scan,
    // which is equivalent to the run tree with saturated lengths.
    bit occ[1:NPOS];

    int errors = 0;
    int beats_in = 0, beats_out = 0;
    int send_idle_pct = 23, recv_idle_pct = 71;
    int hold_off = 0;       // receiver long stall, counted down in the monitor
    bit hold_done = 1'b0;   // long stall already taken
    int quiet_cycles = 0;
    bit driving_done = 1'b0;

    function automatic fit_result_t predict_fit(op_beat_t b);
        fit_result_t r;
        int run, d;
        r = '0;
        if (b.func == FN_INSERT || b.func == FN_REMOVE) begin
            if (b.value < 1 || b.value > NPOS)
                r.status = ST_RANGE;
            else if (b.func == FN_INSERT) begin
                if (occ[b.value]) r.status = ST_SAME;
                else occ[b.value] = 1'b1;
            end else begin
                if (!occ[b.value]) r.status = ST_SAME;
                else occ[b.value] = 1'b0;
            end
        end else if (b.func == FN_QUERY) begin
            // k=0 fits at 1; otherwise leftmost run >= k, else the free tail
            if (b.value == 0) r.answer = 13'd1;
            else begin
                r.answer = 13'(NPOS + 1);
                run = 0;
                for (d = NPOS; d >= 1; d--) begin
                    if (occ[d]) run = 0;
                    else begin
                        run++;
                        // a run touching the tail is saturated and fits anything
                        if (run >= b.value || d + run - 1 == NPOS) r.answer = 13'(d);
                    end
                end
                // keep only the leftmost start of a fitting run
                run = 0;
                for (d = 1; d <= NPOS + 1; d++) begin
                    if (d == NPOS + 1 || occ[d]) begin
                        if (d == NPOS + 1 || run >= b.value) begin
                            r.answer = 13'(d - run);
                            break;
                        end
                        run = 0;
                    end else run++;
                end
            end
        end
        return r;
    endfunction

    // Driver: one beat per handshake; valid held until accepted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && item_ready) begin
                beats_in <= beats_in + 1;
                expected_fits.push_back(predict_fit('{func, value}));
            end
            if (!item_valid || item_ready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op_beat_t b;
                    b = pending_ops.pop_front();
                    item_valid <= 1'b1;
                    func <= b.func;
                    value <= b.value;
                end else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result beat with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && result_ready) begin
                fit_result_t e;
                beats_out <= beats_out + 1;
                if (expected_fits.size() == 0) begin
                    $error("result beat with nothing expected: answer %0d status %0d",
                           answer, status);
                    errors++;
                end else begin
                    e = expected_fits.pop_front();
                    if (answer !== e.answer) begin
                        $error("answer: expected %0d, got %0d", e.answer, answer);
                        errors++;
                    end
                    if (status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                result_ready <= 1'b0;
            end else if (!hold_done && beats_out == 100) begin
                // one long stall early in phase one while the sender keeps offering
                hold_off <= 3000;
                hold_done <= 1'b1;
                result_ready <= 1'b0;
            end else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (rst_n && !driving_done || expected_fits.size() > 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_op(logic [1:0] f, logic [12:0] v);
        pending_ops.push_back('{f, v});
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || item_valid || expected_fits.size() > 0)
            @(posedge clk);
    endtask

    // Mostly in-range positions biased toward a low window so runs form.
    function automatic logic [12:0] rand_pos();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 13'($urandom_range(64, 1));
        if (r < 90) return 13'($urandom_range(NPOS, 1));
        if (r < 95) return 13'($urandom_range(NPOS, NPOS - 8));
        return 13'($urandom);
    endfunction

    task automatic add_random(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 35) add_op(FN_INSERT, rand_pos());
            else if (r < 60) add_op(FN_REMOVE, rand_pos());
            else if (r < 97)
                add_op(FN_QUERY, ($urandom_range(3) == 0) ? 13'($urandom)
                                                          : 13'($urandom_range(12)));
            else add_op(FN_NOP, 13'($urandom));
        end
    endtask

    initial begin
        int i;
        for (i = 1; i <= NPOS; i++) occ[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range edges, repeats, k=0, tail answers, unused code.
        add_op(FN_QUERY, 13'd0);
        add_op(FN_QUERY, 13'h1FFF);
        add_op(FN_INSERT, 13'd0);
        add_op(FN_REMOVE, 13'd4097);
        add_op(FN_INSERT, 13'h1FFF);
        add_op(FN_REMOVE, 13'd5);
        add_op(FN_INSERT, 13'd1);
        add_op(FN_INSERT, 13'd1);
        add_op(FN_INSERT, 13'd3);
        add_op(FN_INSERT, 13'd4096);
        add_op(FN_QUERY, 13'd1);
        add_op(FN_QUERY, 13'd2);
        add_op(FN_QUERY, 13'd4095);
        add_op(FN_QUERY, 13'd4094);
        add_op(FN_INSERT, 13'd2);
        add_op(FN_QUERY, 13'd1);
        add_op(FN_REMOVE, 13'd2);
        add_op(FN_REMOVE, 13'd2);
        add_op(FN_REMOVE, 13'd1);
        add_op(FN_QUERY, 13'd2);
        add_op(FN_NOP, 13'h1555);
        add_op(FN_NOP, 13'h0AAA);
        add_op(FN_REMOVE, 13'd4096);
        add_op(FN_QUERY, 13'd4096);
        wait_drained();

        // Phase one: sender rarely idle, receiver mostly idle; long hold-off.
        add_random(650);
        wait_drained();

        send_idle_pct = 71; recv_idle_pct = 23;
        add_random(650);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        add_random(650);
        wait_drained();

        driving_done = 1'b1;
        repeat (400) @(posedge clk);
        $display("covered %0d item beats and %0d result beats: inserts, removes,", beats_in,
                 beats_out);
        $display("queries incl. k=0, tail fits, range and repeat flags, long result stall");
        if (errors == 0 && expected_fits.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
